// ===== rtl/core/loos_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// loos_pkg
// Shared widths and the result record of the literal occurrence overlap
// scorer.
// ----------------------------------------------------------------------------
package loos_pkg;

    // Stream payload widths
    localparam int LITERAL_W   = 14;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_SCORE_W = 32;
    localparam int OUT_DATA_W  = 32;

    // Width used to compare a literal magnitude against the variable limit
    localparam int MAG_EXT_W   = 32;

    // One result item as it sits in the output queue
    typedef struct packed {
        logic [OUT_SCORE_W-1:0] overlap_score;
        logic                   score_saturated;
    } result_t;

endpackage

// ===== rtl/core/loos_count_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// loos_count_ram
// Single-port-write, single-port-read occurrence counter memory with a
// registered read. A read and a write of the same entry
// in one cycle return the old contents.
// ----------------------------------------------------------------------------
module loos_count_ram #(
    parameter int DEPTH  = 4097,
    parameter int DATA_W = 16
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data
);
    import loos_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Read and write ports
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/loos_result_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// loos_result_fifo
// Two-entry result queue that decouples the scoring pipeline from the
// downstream ready.
// ----------------------------------------------------------------------------
module loos_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  loos_pkg::result_t push_data,
    input  logic              pop_ready,
    output logic              out_valid,
    output loos_pkg::result_t out_data,
    output logic [1:0]        count
);
    import loos_pkg::*;

    result_t    entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop       = (count_reg != 2'd0) && pop_ready;
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/literal_occurrence_overlap_scorer_unit.sv =====
`timescale 1ns / 1ps
// A score-mode clause-end literal is registered in stage 1, then pushed into the result queue, which drives m_tvalid.
// Throughput: one literal per cycle while s_tready is high; the counter RAM read-modify-write uses a one-entry bypass.
// Input stalls while queued results plus a result still in flight fill the two-entry queue,
// so back-to-back clause ends with an always-ready receiver cannot be taken in every cycle.
// Reset: counters clear by a sweep over all MAX_VARIABLES+1 entries, input not ready until done.
// The running clause sum and its saturation flag clear at reset and after each result.
// ----------------------------------------------------------------------------
// literal_occurrence_overlap_scorer_unit
// Per-variable positive/negative occurrence histogram with a clause overlap
// scorer. Count mode bumps a saturating counter; score mode sums count-1 over
// the clause and emits the saturating sum at clause end.
// ----------------------------------------------------------------------------
module literal_occurrence_overlap_scorer_unit #(
    parameter int MAX_VARIABLES = 4096,
    parameter int COUNT_WIDTH   = 16,
    parameter int SCORE_WIDTH   = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // slave side
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [loos_pkg::IN_DATA_W-1:0]   s_tdata,  // [13:0] literal, [15:14] zero
    input  logic                             s_tuser,  // [0] mode
    input  logic                             s_tlast,  // clause_end
    // master side
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [loos_pkg::OUT_DATA_W-1:0]  m_tdata,  // [31:0] overlap_score
    output logic                             m_tuser   // [0] score_saturated
);
    import loos_pkg::*;

    localparam int DEPTH  = MAX_VARIABLES + 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SUM_W  = ((SCORE_WIDTH > COUNT_WIDTH) ? SCORE_WIDTH : COUNT_WIDTH) + 1;
    localparam int EXT_W  = (SCORE_WIDTH > OUT_SCORE_W) ? SCORE_WIDTH : OUT_SCORE_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX     = {COUNT_WIDTH{1'b1}};
    localparam logic [SUM_W-1:0]       SCORE_MAX_EXT = SUM_W'({SCORE_WIDTH{1'b1}});

    // Literal decode
    logic [LITERAL_W-1:0] lit_raw;
    logic [LITERAL_W-1:0] lit_mag;
    logic [MAG_EXT_W-1:0] lit_mag_ext;
    logic                 lit_neg;
    logic                 lit_usable;
    logic [ADDR_W-1:0]    lit_addr;
    logic                 accept;

    // Clear sweep
    logic              clr_active_reg, clr_active_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;

    // Read-modify-write stage
    logic              s1_valid_reg;
    logic              s1_mode_reg;
    logic              s1_last_reg;
    logic              s1_usable_reg;
    logic              s1_neg_reg;
    logic [ADDR_W-1:0] s1_addr_reg;

    // Bypass of the last counter write
    logic                   fw_valid_reg;
    logic                   fw_neg_reg;
    logic [ADDR_W-1:0]      fw_addr_reg;
    logic [COUNT_WIDTH-1:0] fw_data_reg;

    // Running clause sum
    logic [SCORE_WIDTH-1:0] running_score_reg, running_score_next;
    logic                   running_sat_reg, running_sat_next;

    logic [COUNT_WIDTH-1:0] pos_rd_data;
    logic [COUNT_WIDTH-1:0] neg_rd_data;
    logic [COUNT_WIDTH-1:0] cnt_ram;
    logic [COUNT_WIDTH-1:0] cnt_cur;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [COUNT_WIDTH-1:0] score_inc;
    logic                   fwd_hit;
    logic                   s1_count_wr;
    logic                   s1_score_add;
    logic                   s1_emits;
    logic [SUM_W-1:0]       score_sum;
    logic                   score_ovf;
    logic [SCORE_WIDTH-1:0] score_after;
    logic                   sat_after;
    logic [EXT_W-1:0]       score_ext;

    logic                   pos_wr_en;
    logic                   neg_wr_en;
    logic [ADDR_W-1:0]      ram_wr_addr;
    logic [COUNT_WIDTH-1:0] ram_wr_data;

    result_t    push_data;
    result_t    out_data;
    logic [1:0] fifo_count;

    // Input decode: magnitude wraps at 14 bits like the literal field
    assign lit_raw     = s_tdata[LITERAL_W-1:0];
    assign lit_neg     = lit_raw[LITERAL_W-1];
    assign lit_mag     = lit_neg ? (LITERAL_W'(0) - lit_raw) : lit_raw;
    assign lit_mag_ext = MAG_EXT_W'(lit_mag);
    assign lit_usable  = (lit_mag != '0) && (lit_mag_ext <= MAG_EXT_W'(MAX_VARIABLES));
    assign lit_addr    = lit_mag_ext[ADDR_W-1:0];

    // Room for a result that may still come out of stage 1 plus a new one
    assign s1_emits = s1_valid_reg && s1_mode_reg && s1_last_reg;
    assign s_tready = !clr_active_reg && (({1'b0, fifo_count} + {2'b0, s1_emits}) < 3'd2);
    assign accept   = s_tvalid && s_tready;

    // Clear sweep over all counter entries after reset
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            if (clr_addr_reg == ADDR_W'(MAX_VARIABLES))
            begin
                clr_active_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
        end
    end

    // Counter fetch with bypass of the last counter write, held in the fw registers
    assign cnt_ram = s1_neg_reg ? neg_rd_data : pos_rd_data;
    assign fwd_hit = fw_valid_reg && (fw_neg_reg == s1_neg_reg) && (fw_addr_reg == s1_addr_reg);
    assign cnt_cur = fwd_hit ? fw_data_reg : cnt_ram;
    assign cnt_inc = (cnt_cur == COUNT_MAX) ? cnt_cur : (cnt_cur + COUNT_WIDTH'(1));

    assign s1_count_wr  = s1_valid_reg && !s1_mode_reg && s1_usable_reg;
    assign s1_score_add = s1_valid_reg && s1_mode_reg && s1_usable_reg && (cnt_cur != '0);

    // Saturating score accumulate
    assign score_inc   = s1_score_add ? (cnt_cur - COUNT_WIDTH'(1)) : '0;
    assign score_sum   = SUM_W'(running_score_reg) + SUM_W'(score_inc);
    assign score_ovf   = score_sum > SCORE_MAX_EXT;
    assign score_after = score_ovf ? {SCORE_WIDTH{1'b1}} : score_sum[SCORE_WIDTH-1:0];
    assign sat_after   = running_sat_reg || score_ovf;
    assign score_ext   = EXT_W'(score_after);

    always_comb
    begin
        running_score_next = running_score_reg;
        running_sat_next   = running_sat_reg;
        if (s1_emits)
        begin
            running_score_next = '0;
            running_sat_next   = 1'b0;
        end
        else if (s1_valid_reg && s1_mode_reg)
        begin
            running_score_next = score_after;
            running_sat_next   = sat_after;
        end
    end

    assign push_data.overlap_score   = score_ext[OUT_SCORE_W-1:0];
    assign push_data.score_saturated = sat_after;

    // Counter write port: sweep first, then count-mode updates
    always_comb
    begin
        if (clr_active_reg)
        begin
            pos_wr_en   = 1'b1;
            neg_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_reg;
            ram_wr_data = '0;
        end
        else
        begin
            pos_wr_en   = s1_count_wr && !s1_neg_reg;
            neg_wr_en   = s1_count_wr && s1_neg_reg;
            ram_wr_addr = s1_addr_reg;
            ram_wr_data = cnt_inc;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg    <= 1'b1;
            clr_addr_reg      <= '0;
            s1_valid_reg      <= 1'b0;
            fw_valid_reg      <= 1'b0;
            running_score_reg <= '0;
            running_sat_reg   <= 1'b0;
        end
        else
        begin
            clr_active_reg    <= clr_active_next;
            clr_addr_reg      <= clr_addr_next;
            s1_valid_reg      <= accept;
            fw_valid_reg      <= s1_count_wr;
            running_score_reg <= running_score_next;
            running_sat_reg   <= running_sat_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg   <= s_tuser;
            s1_last_reg   <= s_tlast;
            s1_usable_reg <= lit_usable;
            s1_neg_reg    <= lit_neg;
            s1_addr_reg   <= lit_addr;
        end
        fw_neg_reg  <= s1_neg_reg;
        fw_addr_reg <= s1_addr_reg;
        fw_data_reg <= cnt_inc;
    end

    // Occurrence counter memories
    loos_count_ram #(
        .DEPTH  (DEPTH),
        .DATA_W (COUNT_WIDTH)
    ) u_pos_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (lit_addr),
        .rd_data (pos_rd_data),
        .wr_en   (pos_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data)
    );

    loos_count_ram #(
        .DEPTH  (DEPTH),
        .DATA_W (COUNT_WIDTH)
    ) u_neg_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (lit_addr),
        .rd_data (neg_rd_data),
        .wr_en   (neg_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data)
    );

    // Result queue
    loos_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_emits),
        .push_data (push_data),
        .pop_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (out_data),
        .count     (fifo_count)
    );

    assign m_tdata = out_data.overlap_score;
    assign m_tuser = out_data.score_saturated;

    // Checks
    a_sweep_covers_all: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr_active_reg) |-> ($past(clr_addr_reg) == ADDR_W'(MAX_VARIABLES)))
        else $error("counter sweep ended before the last entry");

    a_sum_cleared_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_emits |=> (running_score_reg == '0) && !running_sat_reg)
        else $error("running sum not cleared after a result");

    a_sat_holds_max: assert property (@(posedge clk) disable iff (!rst_n)
        running_sat_reg |-> (running_score_reg == {SCORE_WIDTH{1'b1}}))
        else $error("saturation flag set with sum below maximum");

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s1_emits |-> (fifo_count != 2'd2))
        else $error("result pushed into a full queue");

    a_bypass_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
        s1_count_wr |=> fw_valid_reg && (fw_addr_reg == $past(s1_addr_reg)))
        else $error("bypass register lost a counter write");

endmodule
